// File: hdl/swlc_pkg.sv
// Shared field widths and event codes for the stopwatch lap controller.
package swlc_pkg;

  // Fixed widths of the item fields
  localparam int KIND_W  = 3;
  localparam int NOW_W   = 48;
  localparam int IDX_W   = 3;
  localparam int TOTAL_W = 3;

  // Event codes carried in the kind field; other codes act as a tick
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LAP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESET = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

endpackage

// File: hdl/swlc_in_if.sv
// Event channel: valid/ready handshake with the event payload.
interface swlc_in_if;
  logic                          valid;
  logic                          ready;
  logic [swlc_pkg::KIND_W-1:0]   kind;
  logic [swlc_pkg::NOW_W-1:0]    now;
  logic [swlc_pkg::IDX_W-1:0]    lap_index;

  modport source (output valid, output kind, output now, output lap_index, input ready);
  modport sink   (input valid, input kind, input now, input lap_index, output ready);
endinterface

// File: hdl/swlc_out_if.sv
// Report channel: valid/ready handshake with the status payload.
interface swlc_out_if;
  logic                          valid;
  logic                          ready;
  logic [swlc_pkg::NOW_W-1:0]    elapsed;
  logic                          running;
  logic                          paused;
  logic [swlc_pkg::TOTAL_W-1:0]  lap_total;
  logic [swlc_pkg::NOW_W-1:0]    lap_value;

  modport source (output valid, output elapsed, output running, output paused,
                  output lap_total, output lap_value, input ready);
  modport sink   (input valid, input elapsed, input running, input paused,
                  input lap_total, input lap_value, output ready);
endinterface

// File: hdl/stopwatch_lap_controller.sv
// Stopwatch lap controller: sequencer around one shared add/subtract unit.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+---------------------------------------------
//   req     | in  | req.valid/ready   | kind, now, lap_index
//   rsp     | out | rsp.valid/ready   | elapsed, running, paused, lap_total, lap_value
//
// One item at a time. Tick, lap, reset and pause go from dispatch to the report
// step; a lap read adds a read step; a resume adds a delta and a rebase step, then
// a read step and an add-and-write-back step per stored lap on the single adder.
// The report sits in an output register, so the next item is taken while it waits;
// a stalled report holds the sequencer only at its last step.
// Synchronous reset returns to idle with no laps; lap memory is not cleared.
module stopwatch_lap_controller #(
  parameter int LAP_SLOTS = 7,
  parameter int TIME_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  swlc_in_if.sink           req,
  swlc_out_if.source        rsp
);

  localparam int CW = $clog2(LAP_SLOTS + 1);
  localparam int PW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
  localparam int SW = CW + 1;
  localparam int IW = (CW > swlc_pkg::IDX_W) ? CW : swlc_pkg::IDX_W;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_DELTA,
    S_REBASE,
    S_LAP_RD,
    S_LAP_WR,
    S_OUT
  } state_t;

  state_t                        state;
  logic [swlc_pkg::KIND_W-1:0]   kind_r;
  logic [swlc_pkg::IDX_W-1:0]    idx_r;
  time_t                         now_r;
  time_t                         start_time;
  time_t                         pause_time;
  time_t                         delta;
  logic [CW-1:0]                 lap_count;
  logic [CW-1:0]                 iter;
  logic [PW-1:0]                 head;
  time_t                         lap_value_r;

  logic                          out_valid;
  logic [swlc_pkg::NOW_W-1:0]    elapsed_r;
  logic                          running_r;
  logic                          paused_r;
  logic [swlc_pkg::TOTAL_W-1:0]  lap_total_r;
  logic [swlc_pkg::NOW_W-1:0]    lap_value_o;

  // Lap memory, kept as a ring starting at head
  time_t                         lap_mem [LAP_SLOTS];
  time_t                         mem_rdata;
  logic                          mem_we;
  logic [PW-1:0]                 mem_waddr;
  time_t                         mem_wdata;
  logic [PW-1:0]                 rd_addr;
  logic [PW-1:0]                 app_addr;
  logic [PW-1:0]                 head_inc;

  time_t                         op_a;
  time_t                         op_b;
  logic                          op_sub;
  time_t                         sum;

  logic                          run;
  logic                          is_paused;
  logic                          out_free;
  logic                          laps_full;
  logic                          read_hit;

  // Fold a ring position below twice the slot count back into range
  function automatic logic [PW-1:0] wrap_addr(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(LAP_SLOTS)) ? (s - SW'(LAP_SLOTS)) : s;
    return PW'(r);
  endfunction

  assign run       = (start_time != '0) && (pause_time == '0);
  assign is_paused = (pause_time != '0);
  assign out_free  = !out_valid || rsp.ready;
  assign laps_full = !(lap_count < CW'(LAP_SLOTS));
  assign read_hit  = IW'(idx_r) < IW'(lap_count);

  // Ring addresses for reads, appends and dropping the oldest lap
  assign rd_addr  = wrap_addr(SW'(head) + ((state == S_DISPATCH) ? SW'(idx_r) : SW'(iter)));
  assign app_addr = wrap_addr(SW'(head) + SW'(lap_count));
  assign head_inc = wrap_addr(SW'(head) + SW'(1));

  // Shared adder: a + b or a - b
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state)
      S_DELTA: begin
        op_a   = now_r;
        op_b   = pause_time;
        op_sub = 1'b1;
      end
      S_REBASE: begin
        op_a = start_time;
        op_b = delta;
      end
      S_LAP_WR: begin
        op_a = mem_rdata;
        op_b = delta;
      end
      S_OUT: begin
        op_a   = run ? now_r : pause_time;
        op_b   = start_time;
        op_sub = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign sum = op_a + (op_sub ? ~op_b : op_b) + TIME_BITS'(op_sub);

  // Memory write port: append in dispatch, rebased lap in the resume loop
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = sum;
    if (state == S_DISPATCH && kind_r == swlc_pkg::KIND_LAP && run) begin
      mem_we    = 1'b1;
      mem_waddr = laps_full ? head : app_addr;
      mem_wdata = now_r;
    end else if (state == S_LAP_WR) begin
      mem_we = 1'b1;
    end
  end

  // Write and read the lap memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lap_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= lap_mem[rd_addr];
  end

  // Sequencer, watch state and report register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_time <= '0;
      pause_time <= '0;
      lap_count  <= '0;
      head       <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Drop a taken report; in the report step a new one replaces it
      if (out_valid && rsp.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_r <= req.kind;
            idx_r  <= req.lap_index;
            now_r  <= TIME_BITS'(req.now);
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          lap_value_r <= '0;
          case (kind_r)
            swlc_pkg::KIND_START: begin
              if (start_time == '0 || is_paused) begin
                state <= S_DELTA;
              end else begin
                pause_time <= now_r;
                state      <= S_OUT;
              end
            end
            swlc_pkg::KIND_LAP: begin
              if (run) begin
                if (laps_full) begin
                  head <= head_inc;
                end else begin
                  lap_count <= lap_count + CW'(1);
                end
              end else begin
                lap_count <= '0;
              end
              state <= S_OUT;
            end
            swlc_pkg::KIND_RESET: begin
              start_time <= is_paused ? '0 : now_r;
              pause_time <= '0;
              lap_count  <= '0;
              state      <= S_OUT;
            end
            swlc_pkg::KIND_READ: begin
              state <= read_hit ? S_READ : S_OUT;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_READ: begin
          lap_value_r <= mem_rdata;
          state       <= S_OUT;
        end
        S_DELTA: begin
          delta <= sum;
          state <= S_REBASE;
        end
        S_REBASE: begin
          start_time <= sum;
          pause_time <= '0;
          iter       <= '0;
          state      <= (lap_count == '0) ? S_OUT : S_LAP_RD;
        end
        S_LAP_RD: begin
          state <= S_LAP_WR;
        end
        S_LAP_WR: begin
          iter  <= iter + CW'(1);
          state <= ((iter + CW'(1)) == lap_count) ? S_OUT : S_LAP_RD;
        end
        S_OUT: begin
          if (out_free) begin
            elapsed_r   <= (run || is_paused) ? swlc_pkg::NOW_W'(sum) : '0;
            running_r   <= run;
            paused_r    <= is_paused;
            lap_total_r <= swlc_pkg::TOTAL_W'(lap_count);
            lap_value_o <= swlc_pkg::NOW_W'(lap_value_r);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.elapsed   = elapsed_r;
  assign rsp.running   = running_r;
  assign rsp.paused    = paused_r;
  assign rsp.lap_total = lap_total_r;
  assign rsp.lap_value = lap_value_o;

  // One item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while another is in work");

  // Lap count never exceeds the slot count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    lap_count <= CW'(LAP_SLOTS))
    else $error("lap count beyond slot count");

  // Ring head stays inside the memory
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    SW'(head) < SW'(LAP_SLOTS))
    else $error("lap ring head out of range");

  // A report never shows running and paused together
  a_run_pause: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.running && rsp.paused))
    else $error("report shows running and paused together");

endmodule
